>>> sv/sdr_pkg.sv
package sdr_pkg;
  localparam int NUM_SETS = 2048;
  localparam int NUM_WAYS = 16;
  localparam int ADDR_BITS = 48;
  localparam int SET_W = $clog2(NUM_SETS);
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int LINE_W = ADDR_BITS - 6;
  localparam int AGE_ROW_W = 2 * NUM_WAYS;
  localparam int SIG_ROW_W = 6 * NUM_WAYS;
  localparam int STR_W = LINE_W + 2 + 1 + 4;
  localparam int LEADER_STEP = NUM_SETS / 64;
  localparam int FIFO_DEPTH = 2;
  localparam logic [0:0] OP_VICTIM = 1'b0;
  localparam logic [0:0] OP_UPDATE = 1'b1;
  localparam logic [1:0] REG_STREAM_WINDOW = 2'd0;
  localparam logic [1:0] REG_BRRIP_INTERVAL = 2'd1;

  typedef struct packed {
    logic op;
    logic [SET_W-1:0] set;
    logic [WAY_W-1:0] way;
    logic way_ok;
    logic [LINE_W-1:0] line;
    logic [5:0] sig;
    logic hit;
    logic lead_s;
    logic lead_b;
  } cmd_t;

  function automatic logic [5:0] sig_hash(input logic [ADDR_BITS-1:0] pc);
    logic [ADDR_BITS-1:0] h;
    h = pc ^ (pc >> 6) ^ (pc >> 12);
    return h[5:0];
  endfunction
endpackage

>>> sv/sdr_ram.sv
module sdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> sv/sdr_front.sv
module sdr_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         op,
  input  logic [10:0]                  set_index,
  input  logic [3:0]                   way_index,
  input  logic [sdr_pkg::ADDR_BITS-1:0] phys_addr,
  input  logic [sdr_pkg::ADDR_BITS-1:0] prog_counter,
  input  logic                         was_hit,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output sdr_pkg::cmd_t                cmd
);
  import sdr_pkg::*;

  cmd_t q [FIFO_DEPTH];
  logic [$clog2(FIFO_DEPTH)-1:0] wp, rp;
  logic [$clog2(FIFO_DEPTH):0] cnt;
  cmd_t c;
  logic [31:0] set_ext, rel;
  logic push, pop;

  always_comb begin
    set_ext = 32'(set_index) % NUM_SETS;
    c.op = op;
    c.set = set_ext[SET_W-1:0];
    c.way = way_index[WAY_W-1:0];
    c.way_ok = 32'(way_index) < NUM_WAYS;
    c.line = phys_addr[ADDR_BITS-1:6];
    c.sig = sig_hash(prog_counter);
    c.hit = was_hit;
    rel = set_ext % LEADER_STEP;
    c.lead_s = (rel == 0) && (set_ext < NUM_SETS / 2);
    c.lead_b = ((LEADER_STEP == 1) ? (set_ext >= 1 && set_ext <= NUM_SETS / 2)
                                   : (rel == 1 && set_ext < NUM_SETS / 2));
  end

  assign in_ready = cnt < FIFO_DEPTH;
  assign push = in_valid && in_ready;
  assign cmd_valid = cnt != 0;
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= c;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end
endmodule

>>> sv/sdr_back.sv
module sdr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [6:0]    cfg_data,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  sdr_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [3:0]    victim_way,
  output logic          bypassed,
  output logic          clearing
);
  import sdr_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_TRAIN = 2'd3;

  logic [1:0] state;
  logic [SET_W-1:0] clr;
  cmd_t cur;
  logic [3:0] stream_window;
  logic [6:0] brrip_interval;
  logic [9:0] duel;
  logic [5:0] brrip_count;
  logic [5:0] tsig;

  logic a_we, s_we, t_we, r_we;
  logic [SET_W-1:0] waddr;
  logic [AGE_ROW_W-1:0] a_wd, a_rd;
  logic [SIG_ROW_W-1:0] s_wd, s_rd;
  logic [STR_W-1:0] t_wd, t_rd;
  logic [5:0] r_waddr, r_raddr;
  logic [1:0] r_wd, r_rd;

  sdr_ram #(.WIDTH(AGE_ROW_W), .DEPTH(NUM_SETS)) u_age (
    .clk, .we(a_we), .waddr, .wdata(a_wd), .raddr(cmd.set), .rdata(a_rd));
  sdr_ram #(.WIDTH(SIG_ROW_W), .DEPTH(NUM_SETS)) u_sig (
    .clk, .we(s_we), .waddr, .wdata(s_wd), .raddr(cmd.set), .rdata(s_rd));
  sdr_ram #(.WIDTH(STR_W), .DEPTH(NUM_SETS)) u_str (
    .clk, .we(t_we), .waddr, .wdata(t_wd), .raddr(cmd.set), .rdata(t_rd));
  sdr_ram #(.WIDTH(2), .DEPTH(64)) u_reuse (
    .clk, .we(r_we), .waddr(r_waddr), .wdata(r_wd), .raddr(r_raddr), .rdata(r_rd));

  logic [LINE_W-1:0] prev;
  logic [1:0] run, run_n, top, age_ins;
  logic flag, flag_n, active, bypass, pred_hi, vic_found;
  logic [3:0] cd, cd_n;
  logic [1:0] ages [NUM_WAYS];
  logic [WAY_W-1:0] vic;
  logic [5:0] hsig;
  logic [6:0] iv;
  logic [AGE_ROW_W-1:0] a_upd;
  logic [SIG_ROW_W-1:0] s_upd;

  assign clearing = state == S_CLEAR;
  assign cmd_ready = state == S_IDLE && !(out_valid && !out_ready);
  assign r_raddr = (state == S_EXEC) ? hsig : cmd.sig;

  always_comb begin
    prev = t_rd[STR_W-1 -: LINE_W];
    run = t_rd[6:5];
    flag = t_rd[4];
    cd = t_rd[3:0];
    run_n = run;
    flag_n = flag;
    cd_n = cd;
    if (prev != '0 && ({1'b0, cur.line} == {1'b0, prev} + (LINE_W+1)'(1) ||
                       {1'b0, prev} == {1'b0, cur.line} + (LINE_W+1)'(1))) begin
      if (run < 2'd3) run_n = run + 2'd1;
      if (run_n == 2'd3 && !flag) begin
        flag_n = 1'b1;
        cd_n = stream_window;
      end
    end else begin
      run_n = '0;
      flag_n = 1'b0;
      cd_n = '0;
    end
    if (flag_n && cd_n != 0) cd_n = cd_n - 4'd1;
    active = flag_n && cd_n != 0;
    pred_hi = r_rd >= 2'd2;
    bypass = active && !pred_hi;

    top = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      ages[w] = a_rd[2*w +: 2];
      if (ages[w] > top) top = ages[w];
    end
    vic = '0;
    vic_found = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!vic_found && ages[w] + (2'd3 - top) == 2'd3) begin
        vic = WAY_W'(w);
        vic_found = 1'b1;
      end
    end
    a_upd = a_rd;
    for (int w = 0; w < NUM_WAYS; w++) a_upd[2*w +: 2] = ages[w] + (2'd3 - top);

    hsig = s_rd[6*cur.way +: 6];
    iv = (brrip_interval == 0) ? 7'd1 : (brrip_interval > 7'd64 ? 7'd64 : brrip_interval);
    if (cur.lead_s) age_ins = 2'd2;
    else if (cur.lead_b) age_ins = (brrip_count == 0) ? 2'd3 : 2'd2;
    else age_ins = (duel >= 10'd512) ? 2'd2 : 2'd3;
    if (pred_hi) age_ins = 2'd0;
    s_upd = s_rd;
    s_upd[6*cur.way +: 6] = cur.sig;

    a_we = 1'b0;
    s_we = 1'b0;
    t_we = 1'b0;
    r_we = 1'b0;
    waddr = cur.set;
    a_wd = a_upd;
    s_wd = s_upd;
    t_wd = {cur.line, run_n, flag_n, cd_n};
    r_waddr = cur.sig;
    r_wd = r_rd - 2'd1;
    if (state == S_CLEAR) begin
      a_we = 1'b1;
      s_we = 1'b1;
      t_we = 1'b1;
      r_we = 1'b1;
      waddr = clr;
      a_wd = '1;
      s_wd = '0;
      t_wd = '0;
      r_waddr = clr[5:0];
      r_wd = 2'd1;
    end else if (state == S_EXEC) begin
      if (cur.op == OP_VICTIM) begin
        a_we = 1'b1;
      end else begin
        t_we = 1'b1;
        a_wd = a_rd;
        if (cur.hit) begin
          a_wd[2*cur.way +: 2] = 2'd0;
          a_we = cur.way_ok;
        end else begin
          r_we = r_rd > 2'd0;
          if (!bypass) begin
            a_wd[2*cur.way +: 2] = age_ins;
            a_we = cur.way_ok;
            s_we = cur.way_ok;
          end
        end
      end
    end else if (state == S_TRAIN) begin
      r_waddr = tsig;
      r_wd = r_rd + 2'd1;
      r_we = cur.way_ok && r_rd < 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) cur <= cmd;
    if (state == S_EXEC) begin
      tsig <= hsig;
      victim_way <= (cur.op == OP_VICTIM) ? 4'(vic) : 4'd0;
      bypassed <= (cur.op == OP_UPDATE) && !cur.hit && bypass;
    end
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
      stream_window <= 4'd8;
      brrip_interval <= 7'd32;
      duel <= 10'd512;
      brrip_count <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_STREAM_WINDOW) stream_window <= cfg_data[3:0];
      if (cfg_we && cfg_index == REG_BRRIP_INTERVAL) brrip_interval <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == SET_W'(NUM_SETS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (cmd_valid && cmd_ready) state <= S_EXEC;
        S_EXEC: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
          if (cur.op == OP_UPDATE) begin
            if (cur.hit) begin
              state <= S_TRAIN;
              if (cur.lead_s && duel < 10'd1023) duel <= duel + 10'd1;
              if (cur.lead_b && duel > 10'd0) duel <= duel - 10'd1;
            end else begin
              if (cur.lead_s && duel > 10'd0) duel <= duel - 10'd1;
              if (cur.lead_b && duel < 10'd1023) duel <= duel + 10'd1;
              if (!bypass && !cur.lead_s && cur.lead_b)
                brrip_count <= (7'(brrip_count) + 7'd1 >= iv) ? 6'd0 : brrip_count + 6'd1;
            end
          end
        end
        S_TRAIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> sv/ship_drrip_stream_bypass_replacement.sv
// Cache replacement engine with re-reference ages, set dueling, signature
// reuse prediction and a per-set stream detector.
// The in channel takes one beat per access: op 0 asks for a victim way,
// op 1 updates the state after a hit or fill. Each beat yields one result
// beat on the out channel with victim_way and bypassed.
// A front stage classifies the beat and queues it in a two-entry queue.
// The back stage takes a beat from the queue, reads the set's rows and the
// reuse counter when it takes the beat and writes them back in the next cycle.
// An update that hits then passes through a train state, which trains the
// reuse counter of the stored signature read in the execute state.
// The back stage takes no new beat until it is back in its idle state.
// The result is registered at the end of the execute state.
// After reset the back stage clears all 2048 sets, one per cycle, and
// accepts no work until the clear is done; configuration writes are taken.
// A stalled receiver holds the result register; the back stage then stops
// and the queue fills until in_ready falls.
module ship_drrip_stream_bypass_replacement (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [6:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [10:0]                   set_index,
  input  logic [3:0]                    way_index,
  input  logic [sdr_pkg::ADDR_BITS-1:0] phys_addr,
  input  logic [sdr_pkg::ADDR_BITS-1:0] prog_counter,
  input  logic                          was_hit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    victim_way,
  output logic                          bypassed
);
  import sdr_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready, clearing;

  sdr_front u_front (
    .clk, .rst, .in_valid, .in_ready, .op, .set_index, .way_index,
    .phys_addr, .prog_counter, .was_hit, .cmd_valid, .cmd_ready, .cmd);

  sdr_back u_back (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cmd_valid, .cmd_ready, .cmd,
    .out_valid, .out_ready, .victim_way, .bypassed, .clearing);

  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !cmd_ready) else $error("command taken during clear");
  a_bypass_upd: assert property (@(posedge clk) disable iff (rst)
    out_valid && bypassed |-> victim_way == '0) else $error("bad result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(victim_way))
    else $error("result dropped");
endmodule
